### sv/fdt_sbt_pkg.sv
// Shared widths, token codes and the result record of the structure block tokenizer.
package fdt_sbt_pkg;

   localparam int unsigned AddrWidth  = 48;
   localparam int unsigned WordWidth  = 32;
   localparam int unsigned IndexWidth = 30;
   localparam int unsigned ModeWidth  = 3;
   localparam int unsigned CsrIdxWidth = 1;
   localparam int unsigned RspDataWidth = 3 * AddrWidth + WordWidth;

   // structure block tokens, big-endian word value
   localparam logic [WordWidth-1:0] TOKEN_BEGIN_NODE = 32'h0000_0001;
   localparam logic [WordWidth-1:0] TOKEN_PROP       = 32'h0000_0003;
   localparam logic [WordWidth-1:0] TOKEN_END        = 32'h0000_0009;

   // register indexes
   localparam logic [CsrIdxWidth-1:0] CSR_STRUCT_ADDRESS  = 1'b0;
   localparam logic [CsrIdxWidth-1:0] CSR_STRINGS_ADDRESS = 1'b1;

   // result kinds
   localparam logic KIND_PROPERTY = 1'b0;
   localparam logic KIND_END      = 1'b1;

   typedef struct packed {
      logic                 kind;
      logic [AddrWidth-1:0] node_name_address;
      logic [AddrWidth-1:0] property_name_address;
      logic [AddrWidth-1:0] value_address;
      logic [WordWidth-1:0] value_length;
   } rsp_type;

   // true when any byte of the word is zero
   function automatic logic has_zero_byte(input logic [WordWidth-1:0] w);
      has_zero_byte = (w[31:24] == 8'h00) || (w[23:16] == 8'h00) ||
                      (w[15:8] == 8'h00) || (w[7:0] == 8'h00);
   endfunction

endpackage

### sv/fdt_structure_block_tokenizer.sv
// Flattened device tree structure block tokenizer: words in, property and end records out.
//
//   channel  direction  signals                                  contents
//   req      in         req_tvalid/tready, tdata[31:0], tuser    word, restart flag
//   rsp      out        rsp_tvalid/tready, tdata[175:0], tuser   addresses and length, kind
//   csr      in         csr_we, csr_index, csr_wdata[47:0]       struct / strings address
//
// One word is taken per cycle while the skid entry is empty; its result, if any, enters
// the output stage. Each word passes through the mode register, index counters and three
// 48-bit adders; a two-entry output stage (result register plus skid) holds results.
// req_tready drops only while the skid entry is full, so rsp stalls cost one slot of slack.
// Synchronous active-high reset clears the parse state and empties the output stage.
module fdt_structure_block_tokenizer
   import fdt_sbt_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [WordWidth-1:0]    req_tdata,   // [31:0] word
   input  logic                    req_tuser,   // [0] restart
   // result channel
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RspDataWidth-1:0] rsp_tdata,   // [47:0] node_name_address,
                                                // [95:48] property_name_address,
                                                // [143:96] value_address,
                                                // [175:144] value_length
   output logic                    rsp_tuser,   // [0] kind
   // configuration
   input  logic                    csr_we,
   input  logic [CsrIdxWidth-1:0]  csr_index,
   input  logic [AddrWidth-1:0]    csr_wdata
);

   localparam logic [ModeWidth-1:0] M_TAG  = 3'd0;
   localparam logic [ModeWidth-1:0] M_NAME = 3'd1;
   localparam logic [ModeWidth-1:0] M_LEN  = 3'd2;
   localparam logic [ModeWidth-1:0] M_NOFF = 3'd3;
   localparam logic [ModeWidth-1:0] M_DATA = 3'd4;
   localparam logic [ModeWidth-1:0] M_DONE = 3'd5;

   localparam logic [IndexWidth-1:0] FIRST_NEXT_INDEX = IndexWidth'(1);

   logic [AddrWidth-1:0]  struct_addr_ff, strings_addr_ff;
   logic [ModeWidth-1:0]  mode_ff, mode_in;
   logic [IndexWidth-1:0] next_index_ff, next_index_in;   // index of the word after the current one
   logic [IndexWidth-1:0] node_index_ff, node_index_in;
   logic [IndexWidth-1:0] data_left_ff, data_left_in;
   logic [WordWidth-1:0]  pend_len_ff, pend_len_in;

   logic [ModeWidth-1:0]  cur_mode;
   logic [IndexWidth-1:0] cur_next, cur_node, cur_left;
   logic [WordWidth-1:0]  cur_len;
   logic [WordWidth-1:0]  len_minus1;

   logic                  accept, produce;
   rsp_type               result;
   logic [AddrWidth-1:0]  node_addr, prop_addr, val_addr;

   logic                  out_valid_ff, skid_valid_ff;
   rsp_type               out_data_ff, skid_data_ff;
   logic                  out_free;

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         struct_addr_ff  <= '0;
         strings_addr_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_STRUCT_ADDRESS:  struct_addr_ff  <= csr_wdata;
            CSR_STRINGS_ADDRESS: strings_addr_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;

   // state seen by this word, after an optional restart
   always_comb begin
      if (req_tuser) begin
         cur_mode = M_TAG;
         cur_next = FIRST_NEXT_INDEX;
         cur_node = '0;
         cur_left = '0;
         cur_len  = '0;
      end else begin
         cur_mode = mode_ff;
         cur_next = next_index_ff;
         cur_node = node_index_ff;
         cur_left = data_left_ff;
         cur_len  = pend_len_ff;
      end
   end

   // address sums, all wrapping at 48 bits
   assign node_addr  = struct_addr_ff + {{(AddrWidth-IndexWidth-2){1'b0}}, cur_node, 2'b00};
   assign val_addr   = struct_addr_ff + {{(AddrWidth-IndexWidth-2){1'b0}}, cur_next, 2'b00};
   assign prop_addr  = strings_addr_ff + {{(AddrWidth-WordWidth){1'b0}}, req_tdata};
   assign len_minus1 = cur_len - WordWidth'(1);

   // advance the parser by one word
   always_comb begin
      mode_in       = cur_mode;
      next_index_in = cur_next + IndexWidth'(1);
      node_index_in = cur_node;
      data_left_in  = cur_left;
      pend_len_in   = cur_len;
      produce       = 1'b0;
      result.kind                  = KIND_PROPERTY;
      result.node_name_address     = node_addr;
      result.property_name_address = '0;
      result.value_address         = '0;
      result.value_length          = '0;
      case (cur_mode)
         M_TAG: begin
            if (req_tdata == TOKEN_BEGIN_NODE) begin
               node_index_in = cur_next;
               mode_in       = M_NAME;
            end else if (req_tdata == TOKEN_PROP) begin
               mode_in = M_LEN;
            end else if (req_tdata == TOKEN_END) begin
               produce     = 1'b1;
               result.kind = KIND_END;
               mode_in     = M_DONE;
            end
         end
         M_NAME: begin
            if (has_zero_byte(req_tdata)) begin
               mode_in = M_TAG;
            end
         end
         M_LEN: begin
            pend_len_in = req_tdata;
            mode_in     = M_NOFF;
         end
         M_NOFF: begin
            produce                      = 1'b1;
            result.property_name_address = prop_addr;
            result.value_address         = val_addr;
            result.value_length          = cur_len;
            if (cur_len == '0) begin
               mode_in = M_TAG;
            end else begin
               data_left_in = len_minus1[IndexWidth+1:2];
               mode_in      = M_DATA;
            end
         end
         M_DATA: begin
            if (cur_left == '0) begin
               mode_in = M_TAG;
            end else begin
               data_left_in = cur_left - IndexWidth'(1);
            end
         end
         M_DONE: begin
            // ignore words until the next restart
            next_index_in = cur_next;
         end
         default: begin
            mode_in = M_DONE;
         end
      endcase
   end

   // hold parser state, update on each input transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= M_TAG;
         next_index_ff <= FIRST_NEXT_INDEX;
         node_index_ff <= '0;
         data_left_ff  <= '0;
         pend_len_ff   <= '0;
      end else if (accept) begin
         mode_ff       <= mode_in;
         next_index_ff <= next_index_in;
         node_index_ff <= node_index_in;
         data_left_ff  <= data_left_in;
         pend_len_ff   <= pend_len_in;
      end
   end

   // output register with one skid entry
   assign out_free = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= accept && produce;
         end else begin
            out_valid_ff  <= accept && produce;
         end
      end else if (accept && produce) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_data_ff  <= skid_data_ff;
            skid_data_ff <= result;
         end else begin
            out_data_ff <= result;
         end
      end else if (accept && produce) begin
         skid_data_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_data_ff.kind;
   assign rsp_tdata  = {out_data_ff.value_length, out_data_ff.value_address,
                        out_data_ff.property_name_address, out_data_ff.node_name_address};

`ifndef SYNTHESIS
   // skid entry only fills behind a waiting result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid while output register empty");

   // after the end token nothing comes out until a restart
   a_done_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && mode_ff == M_DONE && !req_tuser) |-> !produce)
      else $error("result produced after end of tree");

   // an end record moves the parser to its done mode
   a_end_to_done: assert property (@(posedge clock) disable iff (reset)
      (accept && produce && result.kind == KIND_END) |=> (mode_ff == M_DONE))
      else $error("end record without done mode");

   // end records carry zero property fields
   a_end_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_END) |->
      (out_data_ff.property_name_address == '0 && out_data_ff.value_address == '0 &&
       out_data_ff.value_length == '0))
      else $error("end record with nonzero property fields");
`endif

endmodule
